[hdl/alr_pkg.sv]
// shared types and constants for the audio level alarm reporter
package alr_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int LEVEL_W           = 32;
    localparam int TIMER_W           = 24;
    localparam int CHAN_W            = 3;
    localparam int QUEUE_DEPTH       = 2;

    // frame layout
    localparam logic [7:0] FRAME_SOF     = 8'hAA;
    localparam logic [7:0] FRAME_LENGTH  = 8'd18;
    localparam logic [7:0] FRAME_VERSION = 8'd1;
    localparam int         FRAME_BYTES   = 22;
    localparam int         BYTE_CNT_W    = $clog2(FRAME_BYTES);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LOW_THRESHOLD  = 2'd0,
        REG_HIGH_THRESHOLD = 2'd1,
        REG_LOW_TIMEOUT    = 2'd2,
        REG_HIGH_TIMEOUT   = 2'd3
    } reg_index_t;

    // request codes
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] low_threshold;
        logic signed [LEVEL_W-1:0] high_threshold;
        logic [TIMER_W-1:0]        low_timeout;
        logic [TIMER_W-1:0]        high_timeout;
    } cfg_t;

    // one queued frame: payload plus alarm status sampled before the update
    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [LEVEL_W-1:0] lvl_left;
        logic [LEVEL_W-1:0] lvl_right;
        logic [LEVEL_W-1:0] lvl_sum;
        logic [LEVEL_W-9:0] diff_upper;
        logic [1:0]         status;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } front_state_t;

endpackage

[hdl/alr_front.sv]
// front end: takes requests, keeps per-channel alarm state, walks timers on ticks
module alr_front
    import alr_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [CHAN_W-1:0]         channel,
    input  logic signed [LEVEL_W-1:0] lvl_left,
    input  logic signed [LEVEL_W-1:0] lvl_right,
    input  logic signed [LEVEL_W-1:0] lvl_sum,
    input  logic signed [LEVEL_W-1:0] lvl_diff,
    output logic                      q_push,
    output desc_t                     q_data,
    input  logic                      q_full
);

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    front_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [2*TIMER_W-1:0] rd_data_reg;

    logic [CHANNEL_COUNT-1:0] alarm_lo_reg, alarm_lo_next;
    logic [CHANNEL_COUNT-1:0] alarm_hi_reg, alarm_hi_next;
    logic [CHANNEL_COUNT-1:0] low_run_reg, low_run_next;
    logic [CHANNEL_COUNT-1:0] high_run_reg, high_run_next;
    // set: elapsed count reads as zero, memory contents stale
    logic [CHANNEL_COUNT-1:0] low_zero_reg, low_zero_next;
    logic [CHANNEL_COUNT-1:0] high_zero_reg, high_zero_next;

    logic [2*TIMER_W-1:0] elapsed_mem [CHANNEL_COUNT];

    logic                 accept;
    logic                 ch_ok;
    logic [IDX_W-1:0]     ch_idx;
    logic                 mem_we;
    logic [TIMER_W-1:0]   lo_eff, hi_eff, lo_new, hi_new;

    assign full   = (state_reg != ST_IDLE) || q_full;
    assign accept = push && !full;
    assign q_push = accept && (cmd == CMD_REPORT);
    assign ch_ok  = 32'(channel) < CHANNEL_COUNT;
    assign ch_idx = IDX_W'(channel);

    assign q_data.channel     = channel;
    assign q_data.lvl_left    = lvl_left;
    assign q_data.lvl_right   = lvl_right;
    assign q_data.lvl_sum     = lvl_sum;
    assign q_data.diff_upper  = lvl_diff[LEVEL_W-1:8];
    assign q_data.status      = ch_ok ? {alarm_hi_reg[ch_idx], alarm_lo_reg[ch_idx]} : 2'b00;

    assign lo_eff = low_zero_reg[rd_idx_reg]  ? '0 : rd_data_reg[TIMER_W-1:0];
    assign hi_eff = high_zero_reg[rd_idx_reg] ? '0 : rd_data_reg[2*TIMER_W-1:TIMER_W];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_TICK))
                begin
                    state_next = ST_WALK;
                    idx_next   = '0;
                end
            end
            ST_WALK:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(CHANNEL_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        alarm_lo_next  = alarm_lo_reg;
        alarm_hi_next  = alarm_hi_reg;
        low_run_next   = low_run_reg;
        high_run_next  = high_run_reg;
        low_zero_next  = low_zero_reg;
        high_zero_next = high_zero_reg;
        mem_we         = 1'b0;
        lo_new         = lo_eff;
        hi_new         = hi_eff;

        // timer step for the channel read last cycle
        if (rd_vld_reg)
        begin
            mem_we = 1'b1;
            low_zero_next[rd_idx_reg]  = 1'b0;
            high_zero_next[rd_idx_reg] = 1'b0;
            if (low_run_reg[rd_idx_reg] && (cfg.low_timeout != '0))
            begin
                lo_new = lo_eff + 1'b1;
                if (lo_new >= cfg.low_timeout)
                begin
                    alarm_lo_next[rd_idx_reg] = 1'b1;
                    low_run_next[rd_idx_reg]  = 1'b0;
                end
            end
            if (high_run_reg[rd_idx_reg] && (cfg.high_timeout != '0))
            begin
                hi_new = hi_eff + 1'b1;
                if (hi_new >= cfg.high_timeout)
                begin
                    alarm_hi_next[rd_idx_reg] = 1'b1;
                    high_run_next[rd_idx_reg] = 1'b0;
                end
            end
        end

        // good levels clear alarms and restart armed timers
        if (q_push && ch_ok)
        begin
            if ((lvl_left > cfg.low_threshold) && (lvl_right > cfg.low_threshold))
            begin
                alarm_lo_next[ch_idx] = 1'b0;
                if (cfg.low_timeout != '0)
                begin
                    low_zero_next[ch_idx] = 1'b1;
                    low_run_next[ch_idx]  = 1'b1;
                end
            end
            if ((lvl_left < cfg.high_threshold) && (lvl_right < cfg.high_threshold))
            begin
                alarm_hi_next[ch_idx] = 1'b0;
                if (cfg.high_timeout != '0)
                begin
                    high_zero_next[ch_idx] = 1'b1;
                    high_run_next[ch_idx]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            alarm_lo_reg  <= '0;
            alarm_hi_reg  <= '0;
            low_run_reg   <= '1;
            high_run_reg  <= '1;
            low_zero_reg  <= '1;
            high_zero_reg <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= (state_reg == ST_WALK);
            rd_idx_reg    <= idx_reg;
            alarm_lo_reg  <= alarm_lo_next;
            alarm_hi_reg  <= alarm_hi_next;
            low_run_reg   <= low_run_next;
            high_run_reg  <= high_run_next;
            low_zero_reg  <= low_zero_next;
            high_zero_reg <= high_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= elapsed_mem[idx_reg];
        if (mem_we)
        begin
            elapsed_mem[rd_idx_reg] <= {hi_new, lo_new};
        end
    end

endmodule

[hdl/alr_queue.sv]
// short queue of frame descriptors between front end and framer
module alr_queue
    import alr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output desc_t rd_data,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/alr_framer.sv]
// back end: serializes one descriptor into a 22-byte frame with checksum
module alr_framer
    import alr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  desc_t       q_data,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    desc_t                 desc_reg;
    logic                  busy_reg, busy_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]            sum_reg, sum_next;
    logic                  take;
    logic                  in_sum;

    assign empty     = !busy_reg;
    assign take      = pop && busy_reg;
    assign last_byte = (cnt_reg == BYTE_CNT_W'(FRAME_BYTES - 1));
    assign q_pop     = !q_empty && (!busy_reg || (take && last_byte));
    assign in_sum    = (cnt_reg >= BYTE_CNT_W'(2)) && (cnt_reg <= BYTE_CNT_W'(19));

    always_comb
    begin
        unique case (cnt_reg)
            BYTE_CNT_W'(0):  frame_byte = FRAME_SOF;
            BYTE_CNT_W'(1):  frame_byte = FRAME_LENGTH;
            BYTE_CNT_W'(2):  frame_byte = FRAME_VERSION;
            BYTE_CNT_W'(3):  frame_byte = 8'(desc_reg.channel);
            BYTE_CNT_W'(4):  frame_byte = desc_reg.lvl_left[31:24];
            BYTE_CNT_W'(5):  frame_byte = desc_reg.lvl_left[23:16];
            BYTE_CNT_W'(6):  frame_byte = desc_reg.lvl_left[15:8];
            BYTE_CNT_W'(7):  frame_byte = desc_reg.lvl_left[7:0];
            BYTE_CNT_W'(8):  frame_byte = desc_reg.lvl_right[31:24];
            BYTE_CNT_W'(9):  frame_byte = desc_reg.lvl_right[23:16];
            BYTE_CNT_W'(10): frame_byte = desc_reg.lvl_right[15:8];
            BYTE_CNT_W'(11): frame_byte = desc_reg.lvl_right[7:0];
            BYTE_CNT_W'(12): frame_byte = desc_reg.lvl_sum[31:24];
            BYTE_CNT_W'(13): frame_byte = desc_reg.lvl_sum[23:16];
            BYTE_CNT_W'(14): frame_byte = desc_reg.lvl_sum[15:8];
            BYTE_CNT_W'(15): frame_byte = desc_reg.lvl_sum[7:0];
            BYTE_CNT_W'(16): frame_byte = desc_reg.diff_upper[23:16];
            BYTE_CNT_W'(17): frame_byte = desc_reg.diff_upper[15:8];
            BYTE_CNT_W'(18): frame_byte = desc_reg.diff_upper[7:0];
            BYTE_CNT_W'(19): frame_byte = 8'(desc_reg.status);
            BYTE_CNT_W'(20): frame_byte = sum_reg;
            default:         frame_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        if (take)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (in_sum)
            begin
                sum_next = sum_reg + frame_byte;
            end
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_data;
        end
    end

endmodule

[hdl/audio_level_alarm_reporter_unit.sv]
// top level of the audio level alarm reporter: config registers, front end, queue, framer
// a report request is accepted while full is low; it passes the queue to the framer once free
// each report yields 22 bytes at one byte per pop, so the framer sets the report rate
// a tick request walks one channel per cycle, then drains; full stays high until idle again
// a two-entry queue lets reports keep arriving while the framer still sends
// rst_n is asynchronous: alarms cleared, timers armed at zero, thresholds and timeouts to defaults
module audio_level_alarm_reporter_unit
    import alr_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request side
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [CHAN_W-1:0]         channel,
    input  logic signed [LEVEL_W-1:0] lvl_left,
    input  logic signed [LEVEL_W-1:0] lvl_right,
    input  logic signed [LEVEL_W-1:0] lvl_sum,
    input  logic signed [LEVEL_W-1:0] lvl_diff,
    // frame byte side
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                frame_byte,
    output logic                      last_byte,
    // configuration writes
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [LEVEL_W-1:0]        cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    desc_t q_wr_data;
    logic  q_full;
    logic  q_pop;
    desc_t q_rd_data;
    logic  q_empty;

    // shared thresholds and timeouts: user writes only while idle, unchecked by the block
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LOW_THRESHOLD:  cfg_next.low_threshold  = cfg_data;
                REG_HIGH_THRESHOLD: cfg_next.high_threshold = cfg_data;
                REG_LOW_TIMEOUT:    cfg_next.low_timeout    = cfg_data[TIMER_W-1:0];
                REG_HIGH_TIMEOUT:   cfg_next.high_timeout   = cfg_data[TIMER_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold  <= '0;
            cfg_reg.high_threshold <= {1'b0, {(LEVEL_W-1){1'b1}}};
            cfg_reg.low_timeout    <= '0;
            cfg_reg.high_timeout   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: alarm state, timer walk, descriptor build
    alr_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .channel     (channel),
        .lvl_left    (lvl_left),
        .lvl_right   (lvl_right),
        .lvl_sum     (lvl_sum),
        .lvl_diff    (lvl_diff),
        .q_push      (q_push),
        .q_data      (q_wr_data),
        .q_full      (q_full)
    );

    // decouples report acceptance from byte delivery
    alr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back end: one frame byte per pop, checksum built on the fly
    alr_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rd_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule
